// ===== design/wmms_pkg.sv =====
package wmms_pkg;

  // Geometry of the statistics store
  localparam int SLOTS       = 16;
  localparam int WINDOWS     = 3;
  localparam int CONV_CH_DEF = 8;
  localparam int BUS_CH_DEF  = 8;

  // Field widths
  localparam int CHAN_W    = 4;
  localparam int WIN_W     = 2;
  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 64;
  localparam int COUNT_W   = 20;
  localparam int ENT_IDX_W = 6;

  // Front-to-back queue and divider shape
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEP    = 8;

  // Input kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Window codes
  localparam logic [WIN_W-1:0] WIN_MINUTE = 2'd0;
  localparam logic [WIN_W-1:0] WIN_HOUR   = 2'd1;
  localparam logic [WIN_W-1:0] WIN_DAY    = 2'd2;

  // Saturation limits
  localparam logic [COUNT_W-1:0]         COUNT_MAX  = '1;
  localparam logic signed [SUM_W-1:0]    SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]    SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic {
    OP_SAMPLE,
    OP_CLEAR
  } op_kind_t;

  // Classified work passed from front to back
  typedef struct packed {
    op_kind_t                    kind;
    logic [CHAN_W-1:0]           chan;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [WIN_W-1:0]            win;
  } op_t;

  // One entry of the statistics store
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic signed [SUM_W-1:0]    sum_v;
    logic [COUNT_W-1:0]         cnt_v;
  } stats_t;

  localparam int STATS_W = $bits(stats_t);

  // Divider request and response
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [COUNT_W-1:0]      count;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] avg;
  } div_rsp_t;

endpackage

// ===== design/windowed_min_max_mean_stats.sv =====
// Channel  Direction  Handshake          Transaction
// in_      input      in_valid/in_stall  sample for one channel, or clear of one window
// out_     output     out_valid/out_stall  statistics of one window for one channel
//
// In the back end a sample is popped, then for each window the store is updated and the
// divider runs load, range check, quotient steps at 8 quotient bits per cycle and clamp;
// a saturating average skips the quotient steps. A clear is done as it is popped.
// Reset clears the entry valid bits, so all statistics read as zero at once.
// The two-entry queue keeps the input side taking transactions, until it fills, while the back
// end works or the output register waits under out_stall.
module windowed_min_max_mean_stats #(
  parameter int CONVERTER_CHANNELS = wmms_pkg::CONV_CH_DEF,
  parameter int BUS_CHANNELS       = wmms_pkg::BUS_CH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_kind,
  input  logic [wmms_pkg::CHAN_W-1:0]            in_channel,
  input  logic signed [wmms_pkg::SAMPLE_W-1:0]   in_sample_value,
  input  logic [wmms_pkg::WIN_W-1:0]             in_window_sel,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [wmms_pkg::WIN_W-1:0]             out_window,
  output logic [wmms_pkg::CHAN_W-1:0]            out_chan_out,
  output logic signed [wmms_pkg::SAMPLE_W-1:0]   out_minimum,
  output logic signed [wmms_pkg::SAMPLE_W-1:0]   out_maximum,
  output logic signed [wmms_pkg::SAMPLE_W-1:0]   out_average,
  output logic signed [wmms_pkg::SUM_W-1:0]      out_total,
  output logic [wmms_pkg::COUNT_W-1:0]           out_sample_count,
  output logic                                   out_last
);

  import wmms_pkg::*;

  // Channels in use, capped by the channel field
  localparam int NCH = (CONVERTER_CHANNELS + BUS_CHANNELS > SLOTS) ?
                       SLOTS : CONVERTER_CHANNELS + BUS_CHANNELS;

  logic push_valid, push_ready;
  op_t  push_data;
  logic pop_valid, pop_ready;
  op_t  pop_data;

  wmms_front #(
    .NCH (NCH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_channel      (in_channel),
    .in_sample_value (in_sample_value),
    .in_window_sel   (in_window_sel),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  wmms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  wmms_back #(
    .NCH (NCH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_window       (out_window),
    .out_chan_out     (out_chan_out),
    .out_minimum      (out_minimum),
    .out_maximum      (out_maximum),
    .out_average      (out_average),
    .out_total        (out_total),
    .out_sample_count (out_sample_count),
    .out_last         (out_last)
  );

endmodule

// ===== design/wmms_ram.sv =====
module wmms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/wmms_div.sv =====
module wmms_div (
  input  logic                clk,
  input  logic                rst_n,
  input  wmms_pkg::div_req_t  req,
  output wmms_pkg::div_rsp_t  rsp
);

  import wmms_pkg::*;

  localparam int STEPS  = SAMPLE_W / DIV_STEP;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [2:0] {
    D_IDLE,
    D_LOAD,
    D_CHECK,
    D_RUN,
    D_FIN,
    D_DONE
  } dstate_t;

  dstate_t                    st_r, st_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [COUNT_W-1:0]         den_r, den_nxt;
  logic                       neg_r, neg_nxt;
  logic [SUM_W-1:0]           mag_r, mag_nxt;
  logic [COUNT_W-1:0]         rem_r, rem_nxt;
  logic [SAMPLE_W-1:0]        lo_r, lo_nxt;
  logic [SAMPLE_W-1:0]        quo_r, quo_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       ovf_r, ovf_nxt;
  logic signed [SAMPLE_W-1:0] avg_r, avg_nxt;

  logic [COUNT_W-1:0]  run_rem;
  logic [SAMPLE_W-1:0] run_lo;
  logic [SAMPLE_W-1:0] run_quo;

  // Eight restoring steps per cycle on the narrow remainder
  always_comb begin
    logic [COUNT_W:0] trial;
    logic [COUNT_W-1:0] r;
    logic [SAMPLE_W-1:0] l;
    logic [SAMPLE_W-1:0] q;
    r = rem_r;
    l = lo_r;
    q = quo_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {r, l[SAMPLE_W-1]};
      l     = {l[SAMPLE_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
        q     = {q[SAMPLE_W-2:0], 1'b1};
      end else begin
        q     = {q[SAMPLE_W-2:0], 1'b0};
      end
      r = trial[COUNT_W-1:0];
    end
    run_rem = r;
    run_lo  = l;
    run_quo = q;
  end

  // Sequence load, range check, quotient steps and signed clamp
  always_comb begin
    st_nxt   = st_r;
    sum_nxt  = sum_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    ovf_nxt  = ovf_r;
    avg_nxt  = avg_r;
    if (req.start) begin
      sum_nxt = req.sum;
      den_nxt = req.count;
      neg_nxt = req.sum[SUM_W-1];
      st_nxt  = D_LOAD;
    end else begin
      case (st_r)
        D_LOAD: begin
          mag_nxt = neg_r ? (~sum_r + SUM_W'(1)) : sum_r;
          st_nxt  = D_CHECK;
        end
        D_CHECK: begin
          // quotient needs more than 32 bits: saturate
          ovf_nxt  = mag_r[SUM_W-1:SAMPLE_W] >= {{(SUM_W-SAMPLE_W-COUNT_W){1'b0}}, den_r};
          rem_nxt  = mag_r[SAMPLE_W+COUNT_W-1:SAMPLE_W];
          lo_nxt   = mag_r[SAMPLE_W-1:0];
          quo_nxt  = '0;
          step_nxt = '0;
          st_nxt   = ovf_nxt ? D_FIN : D_RUN;
        end
        D_RUN: begin
          rem_nxt  = run_rem;
          lo_nxt   = run_lo;
          quo_nxt  = run_quo;
          step_nxt = step_r + 1'b1;
          if (step_r == STEP_W'(STEPS - 1)) begin
            st_nxt = D_FIN;
          end
        end
        D_FIN: begin
          if (ovf_r) begin
            avg_nxt = neg_r ? SAMPLE_MIN : SAMPLE_MAX;
          end else if (!neg_r) begin
            avg_nxt = quo_r[SAMPLE_W-1] ? SAMPLE_MAX : quo_r;
          end else begin
            avg_nxt = quo_r[SAMPLE_W-1] ? SAMPLE_MIN : (~quo_r + SAMPLE_W'(1));
          end
          st_nxt = D_DONE;
        end
        D_IDLE, D_DONE: begin
          st_nxt = st_r;
        end
        default: begin
          st_nxt = D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
    sum_r <= sum_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
    avg_r <= avg_nxt;
  end

  assign rsp.done = (st_r == D_DONE);
  assign rsp.avg  = avg_r;

endmodule

// ===== design/wmms_queue.sv =====
module wmms_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  wmms_pkg::op_t   push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output wmms_pkg::op_t   pop_data
);

  import wmms_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = entry_r[head_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers with wrap, track fill level
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[tail_r] <= push_data;
    end
  end

endmodule

// ===== design/wmms_front.sv =====
module wmms_front #(
  parameter int NCH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_kind,
  input  logic [wmms_pkg::CHAN_W-1:0]            in_channel,
  input  logic signed [wmms_pkg::SAMPLE_W-1:0]   in_sample_value,
  input  logic [wmms_pkg::WIN_W-1:0]             in_window_sel,
  output logic                                   push_valid,
  input  logic                                   push_ready,
  output wmms_pkg::op_t                          push_data
);

  import wmms_pkg::*;

  localparam logic [CHAN_W:0] NCH_LIM = (CHAN_W + 1)'(NCH);

  logic fr_valid_r, fr_valid_nxt;
  op_t  fr_op_r, fr_op_nxt;
  logic accept;
  logic keep;
  op_t  cls_op;

  assign in_stall   = fr_valid_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = fr_valid_r;
  assign push_data  = fr_op_r;

  // Classify: drop clears of an unknown window and samples of absent channels
  always_comb begin
    cls_op.kind   = (in_kind == KIND_CLEAR) ? OP_CLEAR : OP_SAMPLE;
    cls_op.chan   = in_channel;
    cls_op.sample = in_sample_value;
    cls_op.win    = in_window_sel;
    if (in_kind == KIND_CLEAR) begin
      keep = (in_window_sel == WIN_MINUTE) || (in_window_sel == WIN_HOUR) ||
             (in_window_sel == WIN_DAY);
    end else begin
      keep = ({1'b0, in_channel} < NCH_LIM);
    end
  end

  // Hold the classified transaction until the queue takes it
  always_comb begin
    fr_valid_nxt = fr_valid_r && !push_ready;
    fr_op_nxt    = fr_op_r;
    if (accept && keep) begin
      fr_valid_nxt = 1'b1;
      fr_op_nxt    = cls_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_op_r <= fr_op_nxt;
  end

endmodule

// ===== design/wmms_back.sv =====
module wmms_back #(
  parameter int NCH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   pop_valid,
  output logic                                   pop_ready,
  input  wmms_pkg::op_t                          pop_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [wmms_pkg::WIN_W-1:0]             out_window,
  output logic [wmms_pkg::CHAN_W-1:0]            out_chan_out,
  output logic signed [wmms_pkg::SAMPLE_W-1:0]   out_minimum,
  output logic signed [wmms_pkg::SAMPLE_W-1:0]   out_maximum,
  output logic signed [wmms_pkg::SAMPLE_W-1:0]   out_average,
  output logic signed [wmms_pkg::SUM_W-1:0]      out_total,
  output logic [wmms_pkg::COUNT_W-1:0]           out_sample_count,
  output logic                                   out_last
);

  import wmms_pkg::*;

  localparam int NENT = WINDOWS * NCH;
  localparam int AW   = $clog2(NENT);

  typedef enum logic [1:0] {
    B_IDLE,
    B_UPD,
    B_DIV
  } bstate_t;

  bstate_t                    st_r, st_nxt;
  logic [WIN_W-1:0]           win_r, win_nxt;
  logic [CHAN_W-1:0]          chan_r, chan_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [AW-1:0]              rd_addr_r, rd_addr_nxt;
  logic [NENT-1:0]            vld_r, vld_nxt;
  stats_t                     res_r, res_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [WIN_W-1:0]           out_window_r, out_window_nxt;
  logic [CHAN_W-1:0]          out_chan_r, out_chan_nxt;
  logic signed [SAMPLE_W-1:0] out_minimum_r, out_minimum_nxt;
  logic signed [SAMPLE_W-1:0] out_maximum_r, out_maximum_nxt;
  logic signed [SAMPLE_W-1:0] out_average_r, out_average_nxt;
  logic signed [SUM_W-1:0]    out_total_r, out_total_nxt;
  logic [COUNT_W-1:0]         out_count_r, out_count_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       ram_we;
  logic [STATS_W-1:0]         ram_rdata;
  stats_t                     old_st;
  stats_t                     upd_st;
  logic [SUM_W:0]             sum_ext;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  logic                       out_load;

  // Entry index: window-major, channel-minor
  function automatic logic [AW-1:0] ent_addr(input logic [WIN_W-1:0] w,
                                             input logic [CHAN_W-1:0] ch);
    logic [ENT_IDX_W-1:0] base;
    logic [ENT_IDX_W-1:0] e;
    case (w)
      WIN_MINUTE: base = '0;
      WIN_HOUR:   base = ENT_IDX_W'(NCH);
      default:    base = ENT_IDX_W'(2 * NCH);
    endcase
    e = base + ENT_IDX_W'(ch);
    return e[AW-1:0];
  endfunction

  wmms_ram #(
    .WIDTH (STATS_W),
    .DEPTH (NENT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr_r),
    .wdata (upd_st),
    .raddr (rd_addr_nxt),
    .rdata (ram_rdata)
  );

  wmms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Entry not written since the last clear reads as zero
  assign old_st = vld_r[rd_addr_r] ? stats_t'(ram_rdata) : stats_t'('0);

  // Fold the sample into the entry
  always_comb begin
    upd_st = old_st;
    if (old_st.cnt_v == '0) begin
      upd_st.min_v = sample_r;
      upd_st.max_v = sample_r;
    end else begin
      if (sample_r > old_st.max_v) begin
        upd_st.max_v = sample_r;
      end
      if (sample_r < old_st.min_v) begin
        upd_st.min_v = sample_r;
      end
    end
    sum_ext = {old_st.sum_v[SUM_W-1], old_st.sum_v} +
              {{(SUM_W - SAMPLE_W + 1){sample_r[SAMPLE_W-1]}}, sample_r};
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      upd_st.sum_v = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      upd_st.sum_v = sum_ext[SUM_W-1:0];
    end
    upd_st.cnt_v = (old_st.cnt_v == COUNT_MAX) ? old_st.cnt_v : old_st.cnt_v + 1'b1;
  end

  // Sequence: take a transaction; clear one window, or for a sample read, update and report each window
  always_comb begin
    st_nxt        = st_r;
    win_nxt       = win_r;
    chan_nxt      = chan_r;
    sample_nxt    = sample_r;
    rd_addr_nxt   = rd_addr_r;
    vld_nxt       = vld_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    pop_ready     = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.sum   = upd_st.sum_v;
    div_req.count = upd_st.cnt_v;
    case (st_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_data.kind == OP_CLEAR) begin
            for (int wi = 0; wi < WINDOWS; wi++) begin
              for (int ci = 0; ci < NCH; ci++) begin
                if (pop_data.win == WIN_W'(wi)) begin
                  vld_nxt[wi * NCH + ci] = 1'b0;
                end
              end
            end
          end else begin
            chan_nxt    = pop_data.chan;
            sample_nxt  = pop_data.sample;
            win_nxt     = WIN_MINUTE;
            rd_addr_nxt = ent_addr(WIN_MINUTE, pop_data.chan);
            st_nxt      = B_UPD;
          end
        end
      end
      B_UPD: begin
        ram_we             = 1'b1;
        vld_nxt[rd_addr_r] = 1'b1;
        res_nxt            = upd_st;
        div_req.start      = 1'b1;
        st_nxt             = B_DIV;
      end
      B_DIV: begin
        if (div_rsp.done && (!out_valid_r || !out_stall)) begin
          out_load = 1'b1;
          if (win_r == WIN_DAY) begin
            st_nxt = B_IDLE;
          end else begin
            win_nxt     = win_r + 1'b1;
            rd_addr_nxt = ent_addr(win_r + 1'b1, chan_r);
            st_nxt      = B_UPD;
          end
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  // Output register: load a finished window, drop it once taken
  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    out_window_nxt  = out_window_r;
    out_chan_nxt    = out_chan_r;
    out_minimum_nxt = out_minimum_r;
    out_maximum_nxt = out_maximum_r;
    out_average_nxt = out_average_r;
    out_total_nxt   = out_total_r;
    out_count_nxt   = out_count_r;
    out_last_nxt    = out_last_r;
    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_window_nxt  = win_r;
      out_chan_nxt    = chan_r;
      out_minimum_nxt = res_r.min_v;
      out_maximum_nxt = res_r.max_v;
      out_average_nxt = div_rsp.avg;
      out_total_nxt   = res_r.sum_v;
      out_count_nxt   = res_r.cnt_v;
      out_last_nxt    = (win_r == WIN_DAY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    win_r         <= win_nxt;
    chan_r        <= chan_nxt;
    sample_r      <= sample_nxt;
    rd_addr_r     <= rd_addr_nxt;
    res_r         <= res_nxt;
    out_window_r  <= out_window_nxt;
    out_chan_r    <= out_chan_nxt;
    out_minimum_r <= out_minimum_nxt;
    out_maximum_r <= out_maximum_nxt;
    out_average_r <= out_average_nxt;
    out_total_r   <= out_total_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_window       = out_window_r;
  assign out_chan_out     = out_chan_r;
  assign out_minimum      = out_minimum_r;
  assign out_maximum      = out_maximum_r;
  assign out_average      = out_average_r;
  assign out_total        = out_total_r;
  assign out_sample_count = out_count_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_UPD |=> !div_rsp.done)
    else $error("divider reports done right after a new start");

  a_last_on_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_window_r == WIN_DAY)))
    else $error("last flag does not match day window");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r != '0)
    else $error("reported window has zero samples");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_minimum_r <= out_maximum_r)
    else $error("minimum above maximum");

  a_avg_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_total_r[SUM_W-1] |-> !out_average_r[SAMPLE_W-1])
    else $error("negative average from non-negative total");
`endif

endmodule
